/* rtl/bape_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bape_pkg
// Shared types, constants and bit-level helpers for the advertising PDU
// encoder: CRC-24 update, whitening LFSR and byte reversal.
// ----------------------------------------------------------------------------
package bape_pkg;

    localparam int ADDR_W  = 48;
    localparam int CHAN_W  = 6;
    localparam int LEN_W   = 5;
    localparam int CRC_W   = 24;
    localparam int WH_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_INIT   = 24'h555555;
    localparam logic [CRC_W-1:0] CRC_TAPS   = 24'h00065B;
    localparam logic [WH_W-1:0]  WHITE_TAPS = 8'h11;
    localparam logic [7:0]       LEN_BASE   = 8'h06;

    localparam logic [ADDR_W-1:0] RST_ADDRESS = '0;
    localparam logic [CHAN_W-1:0] RST_CHANNEL = 6'd37;
    localparam logic [7:0]        RST_HEADER  = 8'h42;
    localparam logic [LEN_W-1:0]  RST_LENGTH  = 5'd31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd3;

    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic [WH_W-1:0]  wh;
    } t_lfsr_state;

    typedef struct packed {
        logic [WH_W-1:0] wh;
        logic [7:0]      data;
    } t_white;

    function automatic logic [7:0] reverse8(input logic [7:0] a);
        logic [7:0] v;
        for (int k = 0; k < 8; k++) begin
            v[7-k] = a[k];
        end
        return v;
    endfunction

    // CRC-24, data LSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                  input logic [7:0] d);
        logic [CRC_W-1:0] r;
        logic             top;
        r = c;
        for (int k = 0; k < 8; k++) begin
            top = r[CRC_W-1];
            r   = {r[CRC_W-2:0], 1'b0};
            if (top != d[k]) begin
                r = r ^ CRC_TAPS;
            end
        end
        return r;
    endfunction

    // 7-bit whitening LFSR held in 8 bits, bit 7 out, one step per data bit
    function automatic t_white whiten_byte(input logic [WH_W-1:0] w,
                                           input logic [7:0] d);
        t_white r;
        r.wh   = w;
        r.data = d;
        for (int k = 0; k < 8; k++) begin
            if (r.wh[WH_W-1]) begin
                r.wh      = r.wh ^ WHITE_TAPS;
                r.data[k] = ~r.data[k];
            end
            r.wh = {r.wh[WH_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/bape_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bape_if
// Valid/ready channels of the advertising PDU encoder: payload input,
// encoded byte output and configuration write.
// ----------------------------------------------------------------------------
interface bape_pay_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    modport source (output valid, output payload_byte, input ready);
    modport sink   (input valid, input payload_byte, output ready);
endinterface

interface bape_pdu_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_packet;
    modport source (output valid, output out_byte, output end_of_packet, input ready);
    modport sink   (input valid, input out_byte, input end_of_packet, output ready);
endinterface

interface bape_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bape_pkg::CFG_IDX_W-1:0]    index;
    logic [bape_pkg::ADDR_W-1:0]       data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/bape_byte_proc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bape_byte_proc
// One byte through CRC-24 (optional) and whitening, output bit-reversed.
// ----------------------------------------------------------------------------
module bape_byte_proc (
    input  wire bape_pkg::t_lfsr_state i_state,
    input  wire                        i_crc_en,
    input  wire [7:0]                  i_byte,
    output bape_pkg::t_lfsr_state      o_state,
    output logic [7:0]                 o_byte
);

    bape_pkg::t_white w_white;

    always_comb begin
        w_white     = bape_pkg::whiten_byte(i_state.wh, i_byte);
        o_state.wh  = w_white.wh;
        o_state.crc = i_crc_en ? bape_pkg::crc_byte(i_state.crc, i_byte) : i_state.crc;
        o_byte      = bape_pkg::reverse8(w_white.data);
    end

endmodule
`default_nettype wire

/* rtl/ble_adv_pdu_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ble_adv_pdu_encoder
// Advertising PDU builder: header, length, address, payload and CRC-24, all
// whitened and bit-reversed, one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  port    dir  item                          handshake
//  i_pay   in   payload_byte                  valid/ready
//  o_pdu   out  out_byte, end_of_packet       valid/ready
//  i_cfg   in   index, data                   valid/ready (always ready)
//
//  One output byte per cycle unless stalled; a middle payload item is a
//  single output byte, so those stream back to back. The first item of a
//  packet follows 8 header and address bytes; the last adds 3 CRC bytes.
//  The single output register sets the pace. Reset restores the register
//  defaults and starts a new packet. Output stall holds the sequencer.
// ----------------------------------------------------------------------------
module ble_adv_pdu_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bape_pay_if.sink    i_pay,
    bape_pdu_if.source  o_pdu,
    bape_cfg_if.sink    i_cfg
);

    localparam logic [3:0] PH_HDR  = 4'd0;
    localparam logic [3:0] PH_LEN  = 4'd1;
    localparam logic [3:0] PH_ADR0 = 4'd2;
    localparam logic [3:0] PH_ADR1 = 4'd3;
    localparam logic [3:0] PH_ADR2 = 4'd4;
    localparam logic [3:0] PH_ADR3 = 4'd5;
    localparam logic [3:0] PH_ADR4 = 4'd6;
    localparam logic [3:0] PH_ADR5 = 4'd7;
    localparam logic [3:0] PH_PAY  = 4'd8;
    localparam logic [3:0] PH_CRC0 = 4'd9;
    localparam logic [3:0] PH_CRC1 = 4'd10;
    localparam logic [3:0] PH_CRC2 = 4'd11;

    logic [bape_pkg::ADDR_W-1:0] r_address;
    logic [bape_pkg::CHAN_W-1:0] r_channel;
    logic [7:0]                  r_header;
    logic [bape_pkg::LEN_W-1:0]  r_plen;

    logic [bape_pkg::CRC_W-1:0]  r_crc;
    logic [bape_pkg::WH_W-1:0]   r_wh;
    logic [bape_pkg::LEN_W-1:0]  r_count;
    logic [bape_pkg::LEN_W-1:0]  n_count;
    logic                        r_busy;
    logic [3:0]                  r_phase;
    logic [7:0]                  r_pay;
    logic                        r_out_valid;
    logic [7:0]                  r_out_byte;
    logic                        r_out_eop;

    logic                        w_adv;
    logic [bape_pkg::LEN_W-1:0]  w_len;
    logic [bape_pkg::LEN_W-1:0]  w_cnt_inc;
    logic                        w_ends;
    logic                        w_last;
    logic                        w_in_ready;
    logic                        w_in_acc;
    logic                        w_start;
    logic [7:0]                  w_byte;
    logic                        w_crc_en;
    logic [bape_pkg::CRC_W-1:0]  w_crc_c;
    bape_pkg::t_lfsr_state       w_st_in;
    bape_pkg::t_lfsr_state       w_st_out;
    logic [7:0]                  w_enc;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= bape_pkg::RST_ADDRESS;
            r_channel <= bape_pkg::RST_CHANNEL;
            r_header  <= bape_pkg::RST_HEADER;
            r_plen    <= bape_pkg::RST_LENGTH;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bape_pkg::CFG_ADDRESS: r_address <= i_cfg.data;
                bape_pkg::CFG_CHANNEL: r_channel <= i_cfg.data[bape_pkg::CHAN_W-1:0];
                bape_pkg::CFG_HEADER:  r_header  <= i_cfg.data[7:0];
                bape_pkg::CFG_LENGTH:  r_plen    <= i_cfg.data[bape_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencing
    assign w_adv      = r_busy && (!r_out_valid || o_pdu.ready);
    assign w_len      = (r_plen == '0) ? bape_pkg::LEN_W'(1) : r_plen;
    assign w_cnt_inc  = r_count + bape_pkg::LEN_W'(1);
    assign w_ends     = (w_cnt_inc >= w_len);
    assign w_last     = ((r_phase == PH_PAY) && !w_ends) || (r_phase == PH_CRC2);
    assign w_in_ready = !r_busy || (w_adv && w_last);
    assign w_in_acc   = i_pay.valid && w_in_ready;
    assign i_pay.ready = w_in_ready;

    always_comb begin
        n_count = r_count;
        if (w_adv && (r_phase == PH_PAY)) begin
            n_count = w_ends ? '0 : w_cnt_inc;
        end
    end

    // a packet starts when the count (after this cycle's update) is zero
    assign w_start = (n_count == '0);

    // byte selection
    always_comb begin
        w_crc_c = r_crc;
        unique case (r_phase)
            PH_HDR:  w_byte = r_header;
            PH_LEN:  w_byte = bape_pkg::LEN_BASE + {3'b000, w_len};
            PH_ADR0: w_byte = r_address[7:0];
            PH_ADR1: w_byte = r_address[15:8];
            PH_ADR2: w_byte = r_address[23:16];
            PH_ADR3: w_byte = r_address[31:24];
            PH_ADR4: w_byte = r_address[39:32];
            PH_ADR5: w_byte = r_address[47:40];
            PH_PAY:  w_byte = r_pay;
            PH_CRC0: w_byte = bape_pkg::reverse8(w_crc_c[23:16]);
            PH_CRC1: w_byte = bape_pkg::reverse8(w_crc_c[15:8]);
            PH_CRC2: w_byte = bape_pkg::reverse8(w_crc_c[7:0]);
            default: w_byte = '0;
        endcase
    end

    assign w_crc_en = (r_phase <= PH_PAY);

    // registers reload at the header byte
    always_comb begin
        if (r_phase == PH_HDR) begin
            w_st_in.crc = bape_pkg::CRC_INIT;
            w_st_in.wh  = bape_pkg::reverse8({2'b00, r_channel}) | 8'h02;
        end else begin
            w_st_in.crc = r_crc;
            w_st_in.wh  = r_wh;
        end
    end

    bape_byte_proc u_proc (
        .i_state  (w_st_in),
        .i_crc_en (w_crc_en),
        .i_byte   (w_byte),
        .o_state  (w_st_out),
        .o_byte   (w_enc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_HDR;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_acc) begin
                r_busy  <= 1'b1;
                r_phase <= w_start ? PH_HDR : PH_PAY;
            end else if (w_adv) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_phase <= r_phase + 4'd1;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_pdu.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pay <= i_pay.payload_byte;
        end
        if (w_adv) begin
            r_crc      <= w_st_out.crc;
            r_wh       <= w_st_out.wh;
            r_out_byte <= w_enc;
            r_out_eop  <= (r_phase == PH_CRC2);
        end
    end

    assign o_pdu.valid         = r_out_valid;
    assign o_pdu.out_byte      = r_out_byte;
    assign o_pdu.end_of_packet = r_out_eop;

    // checks
    a_eop_after_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_phase == PH_CRC2)) |=> (o_pdu.valid && o_pdu.end_of_packet))
        else $error("end of packet not flagged after last CRC byte");

    a_start_at_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_start) |=> (r_busy && (r_phase == PH_HDR)))
        else $error("packet start did not begin with header byte");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_phase <= PH_CRC2))
        else $error("phase out of range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != {bape_pkg::LEN_W{1'b1}}))
        else $error("payload count overran");

    a_no_eop_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_phase != PH_CRC2)) |=> !o_pdu.end_of_packet)
        else $error("end of packet on a non-final byte");

endmodule
`default_nettype wire
